FILE: rtl/prtc_pkg.sv
// ----------------------------------------------------------------------------
// prtc_pkg
// shared widths, register indexes, threshold mode codes and detector layout
// for the pixel reorder, threshold and calibration block
// ----------------------------------------------------------------------------
package prtc_pkg;

   // frame geometry
   localparam int unsigned FRAME_PIXELS_DEFAULT = 25600;
   localparam int unsigned DET_PIXELS           = 6400;

   // payload widths
   localparam int unsigned ADDR_W = 15;
   localparam int unsigned PIX_W  = 16;
   localparam int unsigned CAL_W  = 32;
   localparam int unsigned K_W    = 13;

   // apb port widths
   localparam int unsigned APB_ADDR_W = 5;
   localparam int unsigned APB_DATA_W = 32;

   // register indexes (byte address = 4 * index)
   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_REORDER_ENABLE     = 3'd0;
   localparam reg_index_type REG_THRESHOLD_MODE     = 3'd1;
   localparam reg_index_type REG_GLOBAL_THRESHOLD   = 3'd2;
   localparam reg_index_type REG_CALIBRATION_ENABLE = 3'd3;
   localparam reg_index_type REG_FRAME_PIXELS       = 3'd4;

   // threshold modes; the unused code acts as none
   typedef logic [1:0] thr_mode_type;
   localparam thr_mode_type THR_NONE   = 2'd0;
   localparam thr_mode_type THR_GLOBAL = 2'd1;
   localparam thr_mode_type THR_PIXEL  = 2'd2;

   // configuration seen by the datapath
   typedef struct packed {
      logic               reorder_enable;
      thr_mode_type       threshold_mode;
      logic [PIX_W-1:0]   global_threshold;
      logic               calibration_enable;
   } cfg_type;

   // first image address of each detector quadrant
   function automatic logic [ADDR_W-1:0] det_start(input logic [1:0] det);
      logic [ADDR_W-1:0] start;
      unique case (det)
         2'd0:    start = 15'd12880;
         2'd1:    start = 15'd12800;
         2'd2:    start = 15'd0;
         default: start = 15'd80;
      endcase
      return start;
   endfunction

endpackage

FILE: rtl/prtc_channels.sv
// ----------------------------------------------------------------------------
// prtc channels
// valid/ready interfaces for the pixel request and result streams
// ----------------------------------------------------------------------------
interface prtc_req_if import prtc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [PIX_W-1:0]        raw_value;
   logic [PIX_W-1:0]        pixel_threshold;
   logic signed [CAL_W-1:0] gradient;
   logic signed [CAL_W-1:0] intercept;

   modport source (output valid, output raw_value, output pixel_threshold,
                   output gradient, output intercept, input ready);
   modport sink   (input valid, input raw_value, input pixel_threshold,
                   input gradient, input intercept, output ready);
endinterface

interface prtc_rsp_if import prtc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   pixel_address;
   logic [PIX_W-1:0]    pixel_value;
   logic                frame_last;

   modport source (output valid, output pixel_address, output pixel_value,
                   output frame_last, input ready);
   modport sink   (input valid, input pixel_address, input pixel_value,
                   input frame_last, output ready);
endinterface

FILE: rtl/prtc_map.sv
// ----------------------------------------------------------------------------
// prtc_map
// readout index to image address, with 180 degree rotation of detectors 0, 1
// ----------------------------------------------------------------------------
module prtc_map import prtc_pkg::*; (
   input  logic [ADDR_W-1:0] index,
   input  logic              reorder_enable,
   output logic [ADDR_W-1:0] address
);

   localparam logic [K_W-1:0] K_LAST = K_W'(DET_PIXELS - 1);

   logic [1:0]      det;
   logic [K_W-1:0]  k_raw;
   logic [K_W-1:0]  k_clamp;
   logic [K_W-1:0]  k;
   logic [8:0]      k_hi;
   logic [16:0]     row_prod;
   logic [6:0]      row;
   logic [K_W-1:0]  row_base;
   logic [K_W-1:0]  row_offset;
   logic [4:0]      col;
   logic [ADDR_W-1:0] mapped;

   always_comb begin
      det     = index[1:0];
      k_raw   = index[ADDR_W-1:2];
      k_clamp = (k_raw > K_LAST) ? K_LAST : k_raw;
      k       = (det[1] == 1'b0) ? (K_LAST - k_clamp) : k_clamp;
      // k div 80 = (k div 16) div 5, reciprocal 205/1024 exact over this range
      k_hi       = k[K_W-1:4];
      row_prod   = 17'(k_hi) * 17'd205;
      row        = row_prod[16:10];
      row_base   = K_W'(row) * K_W'(80);
      row_offset = k - row_base;
      col        = row_offset[6:2];
      mapped     = ADDR_W'(k[1:0]) * ADDR_W'(20) + ADDR_W'(col)
                 + ADDR_W'(row) * ADDR_W'(160) + det_start(det);
      address    = reorder_enable ? mapped : index;
   end

endmodule

FILE: rtl/prtc_value.sv
// ----------------------------------------------------------------------------
// prtc_value
// threshold test and q16.16 gain/offset calibration with saturation
// ----------------------------------------------------------------------------
module prtc_value import prtc_pkg::*; (
   input  logic [PIX_W-1:0]        raw_value,
   input  logic [PIX_W-1:0]        pixel_threshold,
   input  logic signed [CAL_W-1:0] gradient,
   input  logic signed [CAL_W-1:0] intercept,
   input  cfg_type                 cfg,
   output logic [PIX_W-1:0]        pixel_value
);

   localparam int unsigned PROD_W = PIX_W + 1 + CAL_W;
   localparam int unsigned SUM_W  = PROD_W + 1;

   logic signed [PROD_W-1:0] product;
   logic signed [SUM_W-1:0]  sum;
   logic [PIX_W-1:0]         calibrated;
   logic [PIX_W-1:0]         threshold;
   logic                     thr_active;
   logic                     below;

   always_comb begin
      product = $signed({1'b0, raw_value}) * gradient;
      sum     = SUM_W'(product) + SUM_W'(intercept);
      // floor of a non-negative value is the plain shift
      if (sum[SUM_W-1]) begin
         calibrated = '0;
      end else if (|sum[SUM_W-2:PIX_W+16]) begin
         calibrated = '1;
      end else begin
         calibrated = sum[PIX_W+15:16];
      end
   end

   always_comb begin
      thr_active = (cfg.threshold_mode == THR_GLOBAL) || (cfg.threshold_mode == THR_PIXEL);
      threshold  = (cfg.threshold_mode == THR_GLOBAL) ? cfg.global_threshold
                                                      : pixel_threshold;
      below      = raw_value < threshold;
      priority if (thr_active && below) begin
         pixel_value = '0;
      end else if (cfg.calibration_enable && (thr_active || raw_value != '0)) begin
         pixel_value = calibrated;
      end else begin
         pixel_value = raw_value;
      end
   end

endmodule

FILE: rtl/pixel_reorder_threshold_calibrate.sv
// ----------------------------------------------------------------------------
// pixel_reorder_threshold_calibrate
// maps detector readout order to image addresses, thresholds and calibrates
// ----------------------------------------------------------------------------
// a request passes the input and then the result register; throughput is one
// pixel per clock while the receiver is ready, set by the input and result
// registers each holding one pixel with ready passed back through both stages
// reset: synchronous, clears the pipeline valids, the readout position and
// loads the register defaults (reorder on, no threshold, calibration off)
module pixel_reorder_threshold_calibrate import prtc_pkg::*; #(
   parameter int unsigned FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   prtc_req_if.sink              req_if,
   prtc_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [ADDR_W-1:0] FRAME_LEN_MAX = ADDR_W'(FRAME_PIXELS);

   // ---------------------------------------------------------------------
   // register file
   // ---------------------------------------------------------------------
   logic               reorder_enable_ff;
   thr_mode_type       threshold_mode_ff;
   logic [PIX_W-1:0]   global_threshold_ff;
   logic               calibration_enable_ff;
   logic [ADDR_W-1:0]  frame_pixels_ff;
   logic               csr_write;
   reg_index_type      csr_index;
   cfg_type            cfg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         reorder_enable_ff     <= 1'b1;
         threshold_mode_ff     <= THR_NONE;
         global_threshold_ff   <= '0;
         calibration_enable_ff <= 1'b0;
         frame_pixels_ff       <= ADDR_W'(FRAME_PIXELS_DEFAULT);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_REORDER_ENABLE:     reorder_enable_ff     <= pwdata[0];
            REG_THRESHOLD_MODE:     threshold_mode_ff     <= pwdata[1:0];
            REG_GLOBAL_THRESHOLD:   global_threshold_ff   <= pwdata[PIX_W-1:0];
            REG_CALIBRATION_ENABLE: calibration_enable_ff <= pwdata[0];
            REG_FRAME_PIXELS:       frame_pixels_ff       <= pwdata[ADDR_W-1:0];
            default: ;  // addresses past the register list are ignored
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         REG_REORDER_ENABLE:     prdata = APB_DATA_W'(reorder_enable_ff);
         REG_THRESHOLD_MODE:     prdata = APB_DATA_W'(threshold_mode_ff);
         REG_GLOBAL_THRESHOLD:   prdata = APB_DATA_W'(global_threshold_ff);
         REG_CALIBRATION_ENABLE: prdata = APB_DATA_W'(calibration_enable_ff);
         REG_FRAME_PIXELS:       prdata = APB_DATA_W'(frame_pixels_ff);
         default:                prdata = '0;
      endcase
   end

   // change configuration only while idle, unenforced: stages share live values
   assign cfg = '{reorder_enable:     reorder_enable_ff,
                  threshold_mode:     threshold_mode_ff,
                  global_threshold:   global_threshold_ff,
                  calibration_enable: calibration_enable_ff};

   // ---------------------------------------------------------------------
   // pipeline handshake
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_advance;
   logic req_transfer;

   // stage 1 moves on when the result register is empty or being drained
   assign s1_advance   = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_transfer = req_if.valid && req_if.ready;
   assign rsp_if.valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // readout position: effective frame length and index for this transfer
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] position_ff;
   logic [ADDR_W-1:0] position_in;
   logic [ADDR_W-1:0] frame_len;
   logic [ADDR_W-1:0] index_now;
   logic              last_now;

   always_comb begin
      // zero acts as one, anything past the build size is clipped
      if (frame_pixels_ff == '0) begin
         frame_len = ADDR_W'(1);
      end else if (frame_pixels_ff > FRAME_LEN_MAX) begin
         frame_len = FRAME_LEN_MAX;
      end else begin
         frame_len = frame_pixels_ff;
      end
      // a position left beyond a shortened frame restarts the frame
      index_now   = (position_ff >= frame_len) ? '0 : position_ff;
      last_now    = index_now == (frame_len - ADDR_W'(1));
      position_in = last_now ? '0 : (index_now + ADDR_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (req_transfer) begin
         position_ff <= position_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: input register
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0]        s1_raw_ff;
   logic [PIX_W-1:0]        s1_thr_ff;
   logic signed [CAL_W-1:0] s1_gradient_ff;
   logic signed [CAL_W-1:0] s1_intercept_ff;
   logic [ADDR_W-1:0]       s1_index_ff;
   logic                    s1_last_ff;

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_raw_ff       <= req_if.raw_value;
         s1_thr_ff       <= req_if.pixel_threshold;
         s1_gradient_ff  <= req_if.gradient;
         s1_intercept_ff <= req_if.intercept;
         s1_index_ff     <= index_now;
         s1_last_ff      <= last_now;
      end
   end

   // ---------------------------------------------------------------------
   // address map and value path between the two registers
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] map_address;
   logic [PIX_W-1:0]  map_value;

   prtc_map u_map (
      .index          (s1_index_ff),
      .reorder_enable (cfg.reorder_enable),
      .address        (map_address)
   );

   prtc_value u_value (
      .raw_value       (s1_raw_ff),
      .pixel_threshold (s1_thr_ff),
      .gradient        (s1_gradient_ff),
      .intercept       (s1_intercept_ff),
      .cfg             (cfg),
      .pixel_value     (map_value)
   );

   // ---------------------------------------------------------------------
   // stage 2: result register
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0] rsp_address_ff;
   logic [PIX_W-1:0]  rsp_value_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_address_ff <= map_address;
         rsp_value_ff   <= map_value;
         rsp_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_if.pixel_address = rsp_address_ff;
   assign rsp_if.pixel_value   = rsp_value_ff;
   assign rsp_if.frame_last    = rsp_last_ff;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pixel reorder, threshold and calibration block:
// pixels are streamed under random idling, every result transfer is checked
// against an in-bench prediction of address, value and frame marker
// ----------------------------------------------------------------------------
module tb_top import prtc_pkg::*; ();

   // the unused threshold code, which the block treats as none
   localparam thr_mode_type THR_SPARE = 2'd3;

   localparam int unsigned PHASE_COUNT = 9;
   localparam int unsigned PHASE_ITEMS = 194;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES = 20;

   // one pixel as offered to the block
   typedef struct {
      logic [PIX_W-1:0]        raw;
      logic [PIX_W-1:0]        thr;
      logic signed [CAL_W-1:0] grad;
      logic signed [CAL_W-1:0] icpt;
   } pixel_in_type;

   // one predicted result; next_pos is bookkeeping for the position counter
   typedef struct {
      logic [ADDR_W-1:0] address;
      logic [PIX_W-1:0]  value;
      logic              last;
      logic [ADDR_W-1:0] next_pos;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // apb side, quiet from time zero
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [APB_ADDR_W-1:0] paddr   = '0;
   logic [APB_DATA_W-1:0] pwdata  = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   prtc_req_if req_bus ();
   prtc_rsp_if rsp_bus ();

   // shadow copy of the register file, updated at the write edge
   logic              reorder_m = 1'b1;
   thr_mode_type      mode_m    = THR_NONE;
   logic [PIX_W-1:0]  gthr_m    = '0;
   logic              cal_m     = 1'b0;
   logic [ADDR_W-1:0] frame_m   = ADDR_W'(FRAME_PIXELS_DEFAULT);

   // readout position as the bench believes it
   logic [ADDR_W-1:0] readout_pos;

   pixel_in_type  pending_pixels [$];
   pixel_out_type expected_pixels [$];

   int unsigned sender_idle = 0;   // percent of cycles the sender holds back
   int unsigned sink_idle   = 0;   // percent of cycles the receiver holds back
   int          mismatches  = 0;

   // long receiver hold-off, counted in its own process
   int          hold_trigger = 0;
   int          hold_seen;
   int unsigned hold_left;

   pixel_reorder_threshold_calibrate u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   // channel signals known before the first edge
   initial begin
      req_bus.valid           = 1'b0;
      req_bus.raw_value       = '0;
      req_bus.pixel_threshold = '0;
      req_bus.gradient        = '0;
      req_bus.intercept       = '0;
      rsp_bus.ready           = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction: address mapping, threshold, calibration and frame marker
   // ------------------------------------------------------------------------
   function automatic pixel_out_type reorder_and_calibrate(input pixel_in_type px,
                                                           input logic [ADDR_W-1:0] pos);
      pixel_out_type res;
      int unsigned len;
      int unsigned idx;
      int unsigned k;
      int unsigned start;
      logic [PIX_W-1:0] thr;
      logic        pass;
      logic        use_cal;
      longint      raw64;
      longint      acc;

      // out-of-range frame lengths are clamped
      len = 32'(frame_m);
      if (len == 0)
         len = 1;
      if (len > FRAME_PIXELS_DEFAULT)
         len = FRAME_PIXELS_DEFAULT;

      // a position left past the frame end starts a new frame
      idx = 32'(pos);
      if (idx >= len)
         idx = 0;

      if (reorder_m) begin
         k = idx >> 2;
         if (k >= DET_PIXELS)
            k = DET_PIXELS - 1;
         // detectors 0 and 1 are read out rotated by 180 degrees
         if ((idx % 4) < 2)
            k = DET_PIXELS - 1 - k;
         case (idx % 4)
            0:       start = 12880;
            1:       start = 12800;
            2:       start = 0;
            default: start = 80;
         endcase
         res.address = ADDR_W'((k % 4) * 20 + (k % 80) / 4 + (k / 80) * 160 + start);
      end else begin
         res.address = ADDR_W'(idx);
      end

      pass    = 1'b1;
      use_cal = cal_m;
      if (mode_m == THR_GLOBAL || mode_m == THR_PIXEL) begin
         thr  = (mode_m == THR_GLOBAL) ? gthr_m : px.thr;
         pass = (px.raw >= thr);
      end else begin
         // no threshold: zero pixels bypass calibration
         use_cal = cal_m && (px.raw != 0);
      end

      if (!pass) begin
         res.value = '0;
      end else if (use_cal) begin
         raw64 = longint'(px.raw);
         acc   = raw64 * longint'(px.grad) + longint'(px.icpt);
         if (acc < 0)
            res.value = '0;
         else if ((acc >>> 16) > 65535)
            res.value = '1;
         else
            res.value = PIX_W'(acc >>> 16);
      end else begin
         res.value = px.raw;
      end

      res.last     = (idx == len - 1);
      res.next_pos = res.last ? '0 : ADDR_W'(idx + 1);
      return res;
   endfunction

   // random pixel content, biased towards thresholds and sensible gains
   function automatic pixel_in_type random_pixel();
      pixel_in_type px;
      int unsigned  sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       px.raw = '0;
         1:       px.raw = '1;
         2, 3, 4: px.raw = PIX_W'($urandom_range(0, 255));
         5:       px.raw = PIX_W'(gthr_m + $urandom_range(0, 6) - 3);
         default: px.raw = PIX_W'($urandom);
      endcase
      sel = $urandom_range(0, 2);
      case (sel)
         0:       px.thr = PIX_W'(px.raw + $urandom_range(0, 4) - 2);
         1:       px.thr = PIX_W'($urandom);
         default: px.thr = PIX_W'($urandom_range(0, 255));
      endcase
      // mostly gains around unity, sometimes anything at all
      if ($urandom_range(0, 7) == 0)
         px.grad = $urandom;
      else
         px.grad = 32'h0001_0000 + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if ($urandom_range(0, 7) == 0)
         px.icpt = $urandom;
      else
         px.icpt = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: offers queued pixels, predicts each accepted transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : pixel_driver
      pixel_in_type  px;
      pixel_out_type res;
      if (reset) begin
         req_bus.valid <= 1'b0;
         readout_pos = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            px.raw  = req_bus.raw_value;
            px.thr  = req_bus.pixel_threshold;
            px.grad = req_bus.gradient;
            px.icpt = req_bus.intercept;
            res = reorder_and_calibrate(px, readout_pos);
            readout_pos = res.next_pos;
            expected_pixels.push_back(res);
         end
         // a new pixel only once the current one has gone
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
               px = pending_pixels.pop_front();
               req_bus.raw_value       <= px.raw;
               req_bus.pixel_threshold <= px.thr;
               req_bus.gradient        <= px.grad;
               req_bus.intercept       <= px.icpt;
               req_bus.valid           <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor: checks each transfer against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      pixel_out_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected result: address %0d value %0d last %0b",
                           rsp_bus.pixel_address, rsp_bus.pixel_value, rsp_bus.frame_last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_bus.pixel_address !== want.address ||
                   rsp_bus.pixel_value !== want.value ||
                   rsp_bus.frame_last !== want.last) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"mismatch: expected address %0d value %0d last %0b,",
                               " got %0d %0d %0b"},
                              want.address, want.value, want.last, rsp_bus.pixel_address,
                              rsp_bus.pixel_value, rsp_bus.frame_last);
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_idle);
      end
   end

   // hold-off counter, armed by bumping hold_trigger
   always @(posedge clock) begin
      if (reset) begin
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic csr_write(input reg_index_type idx, input logic [APB_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      // the register takes the value at this edge
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_REORDER_ENABLE:     reorder_m = value[0];
         REG_THRESHOLD_MODE:     mode_m    = value[1:0];
         REG_GLOBAL_THRESHOLD:   gthr_m    = value[PIX_W-1:0];
         REG_CALIBRATION_ENABLE: cal_m     = value[0];
         REG_FRAME_PIXELS:       frame_m   = value[ADDR_W-1:0];
         default: ;
      endcase
   endtask

   // block quiet: nothing queued, nothing offered, nothing outstanding
   task automatic wait_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_bus.valid || expected_pixels.size() != 0)
         @(negedge clock);
      // two-stage pipeline, let it settle before returning
      repeat (4) @(negedge clock);
   endtask

   // registers are only touched once the pipeline has emptied
   task automatic set_config(input logic reorder, input thr_mode_type mode,
                             input logic [PIX_W-1:0] gthr, input logic cal,
                             input logic [ADDR_W-1:0] frame);
      wait_drained();
      csr_write(REG_REORDER_ENABLE, APB_DATA_W'(reorder));
      csr_write(REG_THRESHOLD_MODE, APB_DATA_W'(mode));
      csr_write(REG_GLOBAL_THRESHOLD, APB_DATA_W'(gthr));
      csr_write(REG_CALIBRATION_ENABLE, APB_DATA_W'(cal));
      csr_write(REG_FRAME_PIXELS, APB_DATA_W'(frame));
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] raw, input logic [PIX_W-1:0] thr,
                             input logic [CAL_W-1:0] grad, input logic [CAL_W-1:0] icpt);
      pixel_in_type px;
      px.raw  = raw;
      px.thr  = thr;
      px.grad = grad;
      px.icpt = icpt;
      pending_pixels.push_back(px);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [ADDR_W-1:0] frame;
      logic [PIX_W-1:0]  gthr;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, first under the reset defaults
      sender_idle = 28;
      sink_idle   = 66;
      @(negedge clock);
      push_pixel(16'h0000, 16'h0000, 32'h8000_0000, 32'h8000_0000);
      push_pixel(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

      // calibration without threshold: zero bypass, both saturations, exact value
      set_config(1'b1, THR_NONE, 16'd0, 1'b1, 15'd25600);
      push_pixel(16'd0, 16'd0, 32'h0001_0000, 32'h7FFF_FFFF);
      push_pixel(16'hFFFF, 16'd0, 32'h7FFF_FFFF, 32'h0000_0000);
      push_pixel(16'd1, 16'd0, 32'hFFFF_FFFF, 32'h8000_0000);
      push_pixel(16'd3, 16'd0, 32'h0001_8000, 32'h0000_8000);

      // global threshold, just below and exactly at it
      set_config(1'b1, THR_GLOBAL, 16'd100, 1'b1, 15'd25600);
      push_pixel(16'd99, 16'd0, 32'h0001_0000, 32'h0000_0000);
      push_pixel(16'd100, 16'd0, 32'h0002_0000, 32'h0001_0000);

      // per-pixel threshold: zero pixel passing is still calibrated
      set_config(1'b0, THR_PIXEL, 16'hFFFF, 1'b1, 15'd25600);
      push_pixel(16'd0, 16'd0, 32'h0001_0000, 32'h0005_0000);
      push_pixel(16'd5, 16'd6, 32'h0001_0000, 32'h0000_0000);

      // spare threshold code behaves as none, calibration off
      set_config(1'b0, THR_SPARE, 16'hFFFF, 1'b0, 15'd25600);
      push_pixel(16'd7, 16'hFFFF, 32'h0001_0000, 32'h0000_0000);
      push_pixel(16'hFFFF, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);

      // zero frame length acts as one: every pixel ends a frame
      set_config(1'b1, THR_NONE, 16'd0, 1'b0, 15'd0);
      push_pixel(16'd11, 16'd0, 32'h0, 32'h0);
      push_pixel(16'd12, 16'd0, 32'h0, 32'h0);

      // position left past a shortened frame restarts at index zero
      set_config(1'b1, THR_NONE, 16'd0, 1'b0, 15'd12);
      repeat (6)
         push_pixel(PIX_W'($urandom), PIX_W'($urandom), $urandom, $urandom);
      set_config(1'b1, THR_NONE, 16'd0, 1'b0, 15'd4);
      push_pixel(16'd21, 16'd0, 32'h0, 32'h0);
      push_pixel(16'd22, 16'd0, 32'h0, 32'h0);

      // random phases, each with its own register setting
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       frame = 15'd5;
            1:       frame = 15'd1;
            2:       frame = 15'd64;
            3:       frame = 15'd0;
            4:       frame = 15'd37;
            5:       frame = 15'h7FFF;
            6:       frame = 15'd4;
            7:       frame = 15'd200;
            default: frame = 15'd13;
         endcase
         if (p == 1)
            gthr = 16'hFFFF;
         else if (p == 5)
            gthr = 16'h0000;
         else
            gthr = PIX_W'($urandom);
         set_config(p % 2 == 0, thr_mode_type'(p % 4), gthr, p % 3 != 0, frame);

         // idling: slow receiver first, then slow sender, then flat out
         if (p < 3) begin
            sender_idle = 28;
            sink_idle   = 66;
         end else if (p < 6) begin
            sender_idle = 66;
            sink_idle   = 28;
         end else begin
            sender_idle = 0;
            sink_idle   = 0;
         end
         // the receiver stalls for a long stretch while the sender keeps offering
         if (p == 6)
            hold_trigger = hold_trigger + 1;

         repeat (PHASE_ITEMS)
            pending_pixels.push_back(random_pixel());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("[pixel_reorder_threshold_calibrate] OK");
      end else begin
         $display("[pixel_reorder_threshold_calibrate] ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("[pixel_reorder_threshold_calibrate] ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/prtc_pkg.sv
rtl/prtc_channels.sv
rtl/prtc_map.sv
rtl/prtc_value.sv
rtl/pixel_reorder_threshold_calibrate.sv
sim/tb_top.sv
